[hw/rtl/mlp_regression_ewc_trainer_macros.svh]
// Assertion macros for the MLP EWC trainer block
`ifndef MLP_REGRESSION_EWC_TRAINER_MACROS_SVH
`define MLP_REGRESSION_EWC_TRAINER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MLPEWC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlpewc assertion failed");
// next-cycle implication
`define MLPEWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlpewc assertion failed");
`else
`define MLPEWC_ASSERT_SAME(label, clk, rst, ante, cons)
`define MLPEWC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/mlpewc_pkg.sv]
// Shared constants, types and Q16.16 arithmetic helpers for the MLP EWC trainer
`timescale 1ns / 1ps
package mlpewc_pkg;

  localparam int NUM_INPUTS = 5;
  localparam int HIDDEN_ONE = 32;
  localparam int HIDDEN_TWO = 16;

  localparam int N_W1   = HIDDEN_ONE * NUM_INPUTS;
  localparam int N_W2   = HIDDEN_TWO * HIDDEN_ONE;
  localparam int N_W3   = HIDDEN_TWO;
  localparam int N_ALL  = N_W1 + N_W2 + N_W3;
  localparam int OFF_W2 = N_W1;
  localparam int OFF_W3 = N_W1 + N_W2;
  localparam int N_BIAS = HIDDEN_ONE + HIDDEN_TWO + 1;
  localparam int N_ACT  = HIDDEN_ONE + HIDDEN_TWO;

  localparam int DIM_A   = (NUM_INPUTS > HIDDEN_ONE) ? NUM_INPUTS : HIDDEN_ONE;
  localparam int DIM_MAX = (DIM_A > HIDDEN_TWO) ? DIM_A : HIDDEN_TWO;

  localparam int WA = $clog2(N_ALL);
  localparam int BA = $clog2(N_BIAS);
  localparam int AA = $clog2(N_ACT);
  localparam int DW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int XW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

  localparam int LIM1  = 26385;
  localparam int LIM2  = 23174;
  localparam int LIM3  = 43693;
  localparam int Q_ONE = 65536;

  localparam logic [16:0] LR_RESET   = 17'd655;
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  // generator state after its first step from seed 42
  localparam logic [31:0] SEED_FIRST = 32'(42 * 1664525 + 1013904223);

  localparam logic signed [33:0] MAX34 = 34'sd2147483647;
  localparam logic signed [33:0] MIN34 = -34'sd2147483648;
  localparam logic signed [49:0] MAX50 = 50'sd2147483647;
  localparam logic signed [49:0] MIN50 = -50'sd2147483648;

  typedef enum logic [1:0] {
    REQ_PREDICT     = 2'd0,
    REQ_TRAIN       = 2'd1,
    REQ_CONSOLIDATE = 2'd2,
    REQ_REINIT      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    LAY1 = 2'd0,
    LAY2 = 2'd1,
    LAY3 = 2'd2
  } lay_t;

  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [33:0] s);
    if (s > MAX34) return 32'sh7FFF_FFFF;
    if (s < MIN34) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic [31:0] a, input logic [31:0] b);
    return sat_sum($signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b}));
  endfunction

  function automatic logic signed [31:0] qsub(input logic [31:0] a, input logic [31:0] b);
    return sat_sum($signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b}));
  endfunction

  // drop 16 fraction bits (floor) and saturate
  function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
    logic signed [49:0] s;
    s = p[65:16];
    if (s > MAX50) return 32'sh7FFF_FFFF;
    if (s < MIN50) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic logic [31:0] relu(input logic [31:0] a);
    return a[31] ? 32'd0 : a;
  endfunction

  function automatic logic [16:0] lim_of(input logic [WA-1:0] slot);
    if (slot < WA'(OFF_W2)) return 17'(LIM1);
    if (slot < WA'(OFF_W3)) return 17'(LIM2);
    return 17'(LIM3);
  endfunction

  function automatic logic [DW-1:0] nin_last(input lay_t l);
    unique case (l)
      LAY1:    return DW'(NUM_INPUTS - 1);
      LAY2:    return DW'(HIDDEN_ONE - 1);
      default: return DW'(HIDDEN_TWO - 1);
    endcase
  endfunction

  function automatic logic [DW-1:0] nout_last(input lay_t l);
    unique case (l)
      LAY1:    return DW'(HIDDEN_ONE - 1);
      LAY2:    return DW'(HIDDEN_TWO - 1);
      default: return DW'(0);
    endcase
  endfunction

  function automatic logic [AA-1:0] in_base(input lay_t l);
    unique case (l)
      LAY3:    return AA'(HIDDEN_ONE);
      default: return AA'(0);
    endcase
  endfunction

  function automatic logic [AA-1:0] out_base(input lay_t l);
    unique case (l)
      LAY2:    return AA'(HIDDEN_ONE);
      default: return AA'(0);
    endcase
  endfunction

  function automatic logic [BA-1:0] bias_base(input lay_t l);
    unique case (l)
      LAY1:    return BA'(0);
      LAY2:    return BA'(HIDDEN_ONE);
      default: return BA'(HIDDEN_ONE + HIDDEN_TWO);
    endcase
  endfunction

  function automatic logic [WA-1:0] wbase(input lay_t l);
    unique case (l)
      LAY1:    return WA'(0);
      LAY2:    return WA'(OFF_W2);
      default: return WA'(OFF_W3);
    endcase
  endfunction

endpackage

[hw/rtl/mlpewc_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module mlpewc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/mlpewc_mul.sv]
// Shared Q16.16 multiplier: registered full product, floor shift and saturate
`timescale 1ns / 1ps
module mlpewc_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [31:0] res
);
  import mlpewc_pkg::*;

  logic signed [65:0] prod;

  // product register; result is valid the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  assign res = qsat(prod);

endmodule

[hw/rtl/mlpewc_lcg.sv]
// Start-value generator: LCG state and Xavier scaling for weight reload
`timescale 1ns / 1ps
module mlpewc_lcg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic                       step,
  input  logic [mlpewc_pkg::WA-1:0]  slot,
  output logic signed [31:0]         value
);
  import mlpewc_pkg::*;

  logic [31:0]        seed;
  logic signed [25:0] s;
  logic signed [43:0] prod;

  // generator state, already advanced once for the current slot
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      seed <= SEED_FIRST;
    end else if (step) begin
      seed <= seed * LCG_MUL + LCG_ADD;
    end
  end

  // s = 2*(seed >> 8) - 2^24, value = floor(s * lim / 2^24)
  assign s     = $signed({1'b0, seed[31:8], 1'b0}) - 26'sd16777216;
  assign prod  = s * $signed({1'b0, lim_of(slot)});
  assign value = {{12{prod[43]}}, prod[43:24]};

endmodule

[hw/rtl/mlp_regression_ewc_trainer.sv]
// Top level: 5-32-16-1 ReLU regression network with SGD and EWC on one shared multiplier
`timescale 1ns / 1ps
`include "mlp_regression_ewc_trainer_macros.svh"
// Every request runs on one shared 33x33 multiplier under a sequencer, one request at a
// time; in_stall is high from acceptance until the sequencer returns to idle. Predict runs
// the forward pass over all 688 weights row by row. Train runs the forward pass, then
// updates each weight and, above the first layer, forms the backward product, plus each
// bias. Consolidate sweeps every weight and reinit reloads every weight. After reset the
// block reloads the start weights and clears Fisher, anchor and bias memories before it
// accepts a request; configuration writes are taken at any time.
module mlp_regression_ewc_trainer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] feature_0,
  input  logic signed [31:0] feature_1,
  input  logic signed [31:0] feature_2,
  input  logic signed [31:0] feature_3,
  input  logic signed [31:0] feature_4,
  input  logic signed [31:0] target,
  input  logic [16:0]        decay,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] prediction,
  output logic [1:0]         done_kind
);
  import mlpewc_pkg::*;

  localparam logic REG_LR     = 1'b0;
  localparam logic REG_LAMBDA = 1'b1;

  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_INIT    = 25'h0000002,
    S_F_ROW   = 25'h0000004,
    S_F_ROW2  = 25'h0000008,
    S_F_ADDR  = 25'h0000010,
    S_F_MUL   = 25'h0000020,
    S_F_ACC   = 25'h0000040,
    S_F_END   = 25'h0000080,
    S_T_ROW   = 25'h0000100,
    S_T_ROW2  = 25'h0000200,
    S_T_ADDR  = 25'h0000400,
    S_T_M1    = 25'h0000800,
    S_T_M2    = 25'h0001000,
    S_T_M3    = 25'h0002000,
    S_T_M4    = 25'h0004000,
    S_T_M5    = 25'h0008000,
    S_T_M6    = 25'h0010000,
    S_T_BIAS  = 25'h0020000,
    S_T_BIAS2 = 25'h0040000,
    S_C_ADDR  = 25'h0080000,
    S_C_M1    = 25'h0100000,
    S_C_M2    = 25'h0200000,
    S_C_M3    = 25'h0400000,
    S_C_M4    = 25'h0800000,
    S_FIN     = 25'h1000000
  } state_t;

  // control
  state_t        state;
  lay_t          lay;
  logic [DW-1:0] i;
  logic [DW-1:0] j;
  logic [WA-1:0] wp;
  logic          init_out;
  logic [16:0]   lr;
  logic [30:0]   lam;

  // datapath registers
  logic [1:0]  kind;
  logic [31:0] x_q [NUM_INPUTS];
  logic [31:0] tgt;
  logic [16:0] alpha;
  logic [31:0] acc, pred, err, delta, t_b;
  logic [31:0] t_w, t_d, t_act, t_gold, t_pen, t_f, t_g2, t_p;

  // memory ports
  logic [31:0]   wt_rd, fis_rd, anc_rd, bias_rd, act_rd, grad_rd;
  logic          wt_we, fis_we, anc_we, bias_we, act_we, grad_we;
  logic [31:0]   wt_wd, fis_wd, anc_wd, bias_wd, act_wd, grad_wd;
  logic [BA-1:0] bias_ra, bias_wa;
  logic [AA-1:0] act_ra, act_wa, grad_wa;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [31:0] mres;
  logic signed [31:0] lcg_val;

  logic [31:0] inp_c, grad_c, wnew_c, gnew_c;
  logic        free_out;
  logic        accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign free_out = !out_valid || !out_stall;

  // operand selection and derived values
  assign inp_c  = (lay == LAY1) ? x_q[i[XW-1:0]] : act_rd;
  assign grad_c = qadd(mres, t_pen);
  assign wnew_c = qsub(t_w, mres);
  assign gnew_c = qadd((j == DW'(0)) ? 32'd0 : t_gold, mres);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_F_MUL: begin
        ma = sx33(wt_rd);
        mb = sx33(inp_c);
      end
      S_T_M1: begin
        ma = {2'b00, lam};
        mb = sx33(fis_rd);
      end
      S_T_M2: begin
        ma = sx33(mres);
        mb = sx33(t_d);
      end
      S_T_M3: begin
        ma = sx33(delta);
        mb = sx33(t_act);
      end
      S_T_M4: begin
        ma = {16'd0, lr};
        mb = sx33(grad_c);
      end
      S_T_M5: begin
        ma = sx33(wnew_c);
        mb = sx33(delta);
      end
      S_T_BIAS: begin
        ma = {16'd0, lr};
        mb = sx33(delta);
      end
      S_C_M1: begin
        ma = sx33(wt_rd);
        mb = sx33(wt_rd);
      end
      S_C_M2: begin
        ma = {16'd0, alpha};
        mb = sx33(t_f);
      end
      S_C_M3: begin
        ma = {16'd0, 17'(Q_ONE) - alpha};
        mb = sx33(t_g2);
      end
      default: ;
    endcase
  end

  // memory addressing and write enables
  assign act_ra  = (state == S_T_ROW) ? out_base(lay) + AA'(j) : in_base(lay) + AA'(i);
  assign act_wa  = out_base(lay) + AA'(j);
  assign act_we  = (state == S_F_END) && (lay != LAY3);
  assign act_wd  = relu(acc);
  assign grad_wa = in_base(lay) + AA'(i);
  assign grad_we = (state == S_T_M6);
  assign grad_wd = gnew_c;
  assign bias_ra = bias_base(lay) + BA'(j);
  assign bias_wa = (state == S_INIT) ? wp[BA-1:0] : bias_base(lay) + BA'(j);
  assign bias_we = ((state == S_INIT) && (wp < WA'(N_BIAS))) || (state == S_T_BIAS2);
  assign bias_wd = (state == S_INIT) ? 32'd0 : qsub(t_b, mres);
  assign wt_we   = (state == S_INIT) || (state == S_T_M5);
  assign wt_wd   = (state == S_INIT) ? lcg_val : wnew_c;
  assign fis_we  = (state == S_INIT) || (state == S_C_M4);
  assign fis_wd  = (state == S_INIT) ? 32'd0 : qadd(t_p, mres);
  assign anc_we  = fis_we;
  assign anc_wd  = (state == S_INIT) ? 32'd0 : t_w;

  mlpewc_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .res (mres)
  );

  mlpewc_lcg u_lcg (
    .clk     (clk),
    .rst     (rst),
    .restart (accept && (req_type == REQ_REINIT)),
    .step    (state == S_INIT),
    .slot    (wp),
    .value   (lcg_val)
  );

  mlpewc_ram #(.WIDTH(32), .DEPTH(N_ALL)) u_wt (
    .clk (clk), .we (wt_we), .waddr (wp), .wdata (wt_wd), .raddr (wp), .rdata (wt_rd)
  );

  mlpewc_ram #(.WIDTH(32), .DEPTH(N_ALL)) u_fis (
    .clk (clk), .we (fis_we), .waddr (wp), .wdata (fis_wd), .raddr (wp), .rdata (fis_rd)
  );

  mlpewc_ram #(.WIDTH(32), .DEPTH(N_ALL)) u_anc (
    .clk (clk), .we (anc_we), .waddr (wp), .wdata (anc_wd), .raddr (wp), .rdata (anc_rd)
  );

  mlpewc_ram #(.WIDTH(32), .DEPTH(N_BIAS)) u_bias (
    .clk (clk), .we (bias_we), .waddr (bias_wa), .wdata (bias_wd),
    .raddr (bias_ra), .rdata (bias_rd)
  );

  mlpewc_ram #(.WIDTH(32), .DEPTH(N_ACT)) u_act (
    .clk (clk), .we (act_we), .waddr (act_wa), .wdata (act_wd),
    .raddr (act_ra), .rdata (act_rd)
  );

  mlpewc_ram #(.WIDTH(32), .DEPTH(N_ACT)) u_grad (
    .clk (clk), .we (grad_we), .waddr (grad_wa), .wdata (grad_wd),
    .raddr (act_ra), .rdata (grad_rd)
  );

  // sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      lay       <= LAY1;
      i         <= '0;
      j         <= '0;
      wp        <= '0;
      init_out  <= 1'b0;
      out_valid <= 1'b0;
      lr        <= LR_RESET;
      lam       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LR:     lr  <= cfg_data[16:0];
          REG_LAMBDA: lam <= cfg_data;
          default: ;
        endcase
      end

      // result register: load from the sequencer, clear once taken
      if ((state == S_FIN) && free_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            i   <= '0;
            j   <= '0;
            wp  <= '0;
            lay <= LAY1;
            case (req_type) inside
              REQ_PREDICT, REQ_TRAIN: state <= S_F_ROW;
              REQ_CONSOLIDATE:        state <= S_C_ADDR;
              default: begin
                init_out <= 1'b1;
                state    <= S_INIT;
              end
            endcase
          end
        end

        // start-value reload and store clearing, one slot per cycle
        S_INIT: begin
          if (wp == WA'(N_ALL - 1)) begin
            wp       <= '0;
            init_out <= 1'b0;
            state    <= init_out ? S_FIN : S_IDLE;
          end else begin
            wp <= wp + WA'(1);
          end
        end

        // forward pass
        S_F_ROW:  state <= S_F_ROW2;
        S_F_ROW2: state <= S_F_ADDR;
        S_F_ADDR: state <= S_F_MUL;
        S_F_MUL:  state <= S_F_ACC;
        S_F_ACC: begin
          wp <= wp + WA'(1);
          if (i == nin_last(lay)) begin
            i     <= '0;
            state <= S_F_END;
          end else begin
            i     <= i + DW'(1);
            state <= S_F_ADDR;
          end
        end
        S_F_END: begin
          if (lay == LAY3) begin
            if (kind == REQ_TRAIN) begin
              j     <= '0;
              i     <= '0;
              wp    <= wbase(LAY3);
              state <= S_T_ROW;
            end else begin
              state <= S_FIN;
            end
          end else if (j == nout_last(lay)) begin
            j     <= '0;
            lay   <= lay_t'(lay + 2'd1);
            state <= S_F_ROW;
          end else begin
            j     <= j + DW'(1);
            state <= S_F_ROW;
          end
        end

        // training, output layer first
        S_T_ROW:  state <= S_T_ROW2;
        S_T_ROW2: state <= S_T_ADDR;
        S_T_ADDR: state <= S_T_M1;
        S_T_M1:   state <= S_T_M2;
        S_T_M2:   state <= S_T_M3;
        S_T_M3:   state <= S_T_M4;
        S_T_M4:   state <= S_T_M5;
        S_T_M5: begin
          if (lay != LAY1) begin
            state <= S_T_M6;
          end else begin
            wp <= wp + WA'(1);
            if (i == nin_last(lay)) begin
              i     <= '0;
              state <= S_T_BIAS;
            end else begin
              i     <= i + DW'(1);
              state <= S_T_ADDR;
            end
          end
        end
        S_T_M6: begin
          wp <= wp + WA'(1);
          if (i == nin_last(lay)) begin
            i     <= '0;
            state <= S_T_BIAS;
          end else begin
            i     <= i + DW'(1);
            state <= S_T_ADDR;
          end
        end
        S_T_BIAS: state <= S_T_BIAS2;
        S_T_BIAS2: begin
          if (j == nout_last(lay)) begin
            j <= '0;
            if (lay == LAY1) begin
              state <= S_FIN;
            end else begin
              lay   <= lay_t'(lay - 2'd1);
              wp    <= wbase(lay_t'(lay - 2'd1));
              state <= S_T_ROW;
            end
          end else begin
            j     <= j + DW'(1);
            state <= S_T_ROW;
          end
        end

        // consolidation sweep
        S_C_ADDR: state <= S_C_M1;
        S_C_M1:   state <= S_C_M2;
        S_C_M2:   state <= S_C_M3;
        S_C_M3:   state <= S_C_M4;
        S_C_M4: begin
          if (wp == WA'(N_ALL - 1)) begin
            wp    <= '0;
            state <= S_FIN;
          end else begin
            wp    <= wp + WA'(1);
            state <= S_C_ADDR;
          end
        end

        // hand the result to the output register once it is free
        S_FIN: begin
          if (free_out) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind   <= req_type;
      x_q[0] <= feature_0;
      x_q[1] <= feature_1;
      x_q[2] <= feature_2;
      x_q[3] <= feature_3;
      x_q[4] <= feature_4;
      tgt    <= target;
      alpha  <= (decay > 17'(Q_ONE)) ? 17'(Q_ONE) : decay;
    end

    case (state)
      S_F_ROW2: acc <= bias_rd;
      S_F_ACC:  acc <= qadd(acc, mres);
      S_F_END: begin
        if (lay == LAY3) begin
          pred <= acc;
          err  <= qsub(acc, tgt);
        end
      end
      // row delta: error at the output, else masked backward sum
      S_T_ROW2: begin
        delta <= (lay == LAY3) ? err : ((act_rd != 32'd0) ? grad_rd : 32'd0);
        t_b   <= bias_rd;
      end
      S_T_M1: begin
        t_w    <= wt_rd;
        t_d    <= qsub(wt_rd, anc_rd);
        t_act  <= inp_c;
        t_gold <= grad_rd;
      end
      S_T_M3: t_pen <= mres;
      S_C_M1: begin
        t_w <= wt_rd;
        t_f <= fis_rd;
      end
      S_C_M2: t_g2 <= mres;
      S_C_M3: t_p  <= mres;
      S_FIN: begin
        if (free_out) begin
          prediction <= ((kind == REQ_PREDICT) || (kind == REQ_TRAIN)) ? pred : 32'd0;
          done_kind  <= kind;
        end
      end
      default: ;
    endcase
  end

  // checks
  `MLPEWC_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall)
  `MLPEWC_ASSERT_NEXT(a_fin_delivers, clk, rst, (state == S_FIN) && !out_valid, out_valid)
  `MLPEWC_ASSERT_SAME(a_result_from_fin, clk, rst, $rose(out_valid), $past(state) == S_FIN)

endmodule
